// File: rtl/jrdt_pkg.sv
// shared types, constants and the cordic arctangent table for the radial dead zone block
// no dependencies
package jrdt_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int RAW_W   = 16;
  localparam int LVL_W   = 15;
  localparam int S_W     = 32;
  localparam int RAD_W   = 60;
  localparam int Q_W     = 30;
  localparam int NUM_W   = 46;
  localparam int QUO_W   = 16;
  localparam int STEP_W  = 5;
  localparam int CX_W    = 28;
  localparam int CZ_W    = 26;

  localparam logic [STEP_W-1:0] SQRT_LAST_STEP = 5'd29;
  localparam logic [STEP_W-1:0] DIV_LAST_STEP  = 5'd15;
  localparam logic [LVL_W-1:0]  UNIT_M         = 15'd16384;
  localparam logic signed [RAW_W-1:0] ANGLE_LIM = 16'sd23040;

  localparam logic [1:0] REG_INNER   = 2'd0;
  localparam logic [1:0] REG_OUTER   = 2'd1;
  localparam logic [1:0] REG_TILT_ON = 2'd2;
  localparam logic [1:0] REG_TILT_OFF = 2'd3;

  localparam logic [LVL_W-1:0] INNER_RST    = 15'd4915;
  localparam logic [LVL_W-1:0] OUTER_RST    = 15'd14746;
  localparam logic [LVL_W-1:0] TILT_ON_RST  = 15'd8192;
  localparam logic [LVL_W-1:0] TILT_OFF_RST = 15'd4096;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQRT,
    OP_DECIDE,
    OP_DIV,
    OP_TAKE_M,
    OP_MUL_X,
    OP_MUL_Y,
    OP_TAKE_X,
    OP_TAKE_Y,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_DECIDE,
    ST_MDIV,
    ST_TAKE_M,
    ST_CHECK,
    ST_MUL_X,
    ST_DIV_X,
    ST_TAKE_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_TAKE_Y,
    ST_WAIT,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic need_mdiv;
    logic m_zero;
    logic cordic_done;
  } dp_stat_t;

  // arctangent of 2^-i in 1/65536 degree
  function automatic logic [CZ_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [CZ_W-1:0] v;
    unique case (i)
      5'd0:  v = 26'd2949120;
      5'd1:  v = 26'd1740967;
      5'd2:  v = 26'd919879;
      5'd3:  v = 26'd466945;
      5'd4:  v = 26'd234379;
      5'd5:  v = 26'd117304;
      5'd6:  v = 26'd58666;
      5'd7:  v = 26'd29335;
      5'd8:  v = 26'd14668;
      5'd9:  v = 26'd7334;
      5'd10: v = 26'd3667;
      5'd11: v = 26'd1833;
      5'd12: v = 26'd917;
      5'd13: v = 26'd458;
      5'd14: v = 26'd229;
      5'd15: v = 26'd115;
      5'd16: v = 26'd57;
      5'd17: v = 26'd29;
      5'd18: v = 26'd14;
      5'd19: v = 26'd7;
      5'd20: v = 26'd4;
      5'd21: v = 26'd2;
      5'd22: v = 26'd1;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/joystick_radial_deadzone_tilt.sv
// joystick radial dead zone: an accepted sample is squared per axis, then takes a 30-step
// square root, a 16-step remap divide when the magnitude lies between the radii and
// 16-step divides for x and y unless the magnitude is zero; the controller goes back to
// idle before the next acceptance, so the block works on one item at a time.
// a finished result waits in the output register; the next one stalls until it is taken.
// rst_n is synchronous: level and state registers reset, all direction flags release.
module joystick_radial_deadzone_tilt import jrdt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // raw_x[15:0], raw_y[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  // corrected_x[15:0], corrected_y[31:16], magnitude[46:32], angle[62:47],
  // tilt_pressed[66:63], tilt_just_pressed[70:67], bit 71 always 0
  output logic [71:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  logic [LVL_W-1:0] inner_r, outer_r, on_r, off_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic signed [RAW_W-1:0] cx, cy, ang;
  logic [LVL_W-1:0] mag;
  logic [3:0] pressed, just;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= INNER_RST;
      outer_r <= OUTER_RST;
      on_r    <= TILT_ON_RST;
      off_r   <= TILT_OFF_RST;
    end else if (cfg_valid && cfg_index[7:2] == '0) begin
      unique case (cfg_index[1:0])
        REG_INNER:    inner_r <= cfg_data;
        REG_OUTER:    outer_r <= cfg_data;
        REG_TILT_ON:  on_r    <= cfg_data;
        REG_TILT_OFF: off_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  jrdt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  jrdt_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .raw_x             (in_tdata[15:0]),
    .raw_y             (in_tdata[31:16]),
    .inner_dz          (inner_r),
    .outer_dz          (outer_r),
    .tilt_on           (on_r),
    .tilt_off          (off_r),
    .stat              (stat),
    .corrected_x       (cx),
    .corrected_y       (cy),
    .magnitude         (mag),
    .angle             (ang),
    .tilt_pressed      (pressed),
    .tilt_just_pressed (just)
  );

  assign out_tdata = {1'b0, just, pressed, ang, mag, cy, cx};

endmodule

// File: rtl/jrdt_cordic.sv
// iterative cordic vectoring unit, one micro-rotation per cycle
// depends on jrdt_pkg
module jrdt_cordic import jrdt_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [RAW_W-1:0] x_in,
  input  logic signed [RAW_W-1:0] y_in,
  output logic                    done,
  output logic signed [RAW_W-1:0] angle
);

  localparam int CW = $clog2(STEPS + 1);

  logic                   busy_r, busy_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic signed [CX_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CZ_W-1:0] z_r, z_nxt;
  logic signed [CX_W-1:0] xs, ys, dx, dy;
  logic signed [CZ_W-1:0] zr;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    xs = CX_W'(x_in) <<< 8;
    ys = CX_W'(y_in) <<< 8;
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // quadrant pre-rotation for the left half plane
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_nxt = ys;
          y_nxt = -xs;
          z_nxt = 26'sd5898240;
        end else begin
          x_nxt = -ys;
          y_nxt = xs;
          z_nxt = -26'sd5898240;
        end
      end else begin
        x_nxt = xs;
        y_nxt = ys;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + $signed(atan_lut(STEP_W'(cnt_r)));
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - $signed(atan_lut(STEP_W'(cnt_r)));
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  always_comb begin
    zr = (z_r + 26'sd256) >>> 9;
    if (zr > CZ_W'(ANGLE_LIM)) begin
      angle = ANGLE_LIM;
    end else if (zr < -CZ_W'(ANGLE_LIM)) begin
      angle = -ANGLE_LIM;
    end else begin
      angle = RAW_W'(zr);
    end
  end

  assign done = !busy_r && !start;

endmodule

// File: rtl/jrdt_datapath.sv
// datapath: shared multiplier, bit-serial square root, long divider, tilt flags, result register
// depends on jrdt_pkg and jrdt_cordic
module jrdt_datapath import jrdt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  input  logic signed [RAW_W-1:0] raw_x,
  input  logic signed [RAW_W-1:0] raw_y,
  input  logic [LVL_W-1:0]        inner_dz,
  input  logic [LVL_W-1:0]        outer_dz,
  input  logic [LVL_W-1:0]        tilt_on,
  input  logic [LVL_W-1:0]        tilt_off,
  output dp_stat_t                stat,
  output logic signed [RAW_W-1:0] corrected_x,
  output logic signed [RAW_W-1:0] corrected_y,
  output logic [LVL_W-1:0]        magnitude,
  output logic signed [RAW_W-1:0] angle,
  output logic [3:0]              tilt_pressed,
  output logic [3:0]              tilt_just_pressed
);

  logic signed [RAW_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [S_W-1:0]          s_r, s_nxt;
  logic [RAD_W-1:0]        n_r, n_nxt, res_r, res_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [Q_W-1:0]          den_r, den_nxt;
  logic [QUO_W-1:0]        quo_r, quo_nxt;
  logic [LVL_W-1:0]        m_r, m_nxt;
  logic signed [RAW_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [3:0]              flags_r, flags_nxt;
  logic signed [RAW_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt, oa_r, oa_nxt;
  logic [LVL_W-1:0]        om_r, om_nxt;
  logic [3:0]              op_r, op_nxt, oj_r, oj_nxt;

  logic [RAW_W-1:0]  abs_x, abs_y, mul_a, mul_b;
  logic [S_W-1:0]    prod;
  logic [S_W-1:0]    s_sum;
  logic [RAD_W-1:0]  bit_v, sq_try;
  logic [NUM_W-1:0]  trial;
  logic [Q_W-1:0]    q;
  logic [Q_W-1:0]    ib, ob;
  logic              unit_c, zero_c, remap_c;
  logic [RAW_W-1:0]  r16, r_cl;
  logic [LVL_W-1:0]  qc;
  logic              cordic_start, cordic_done;
  logic signed [RAW_W-1:0] cordic_angle;
  logic signed [LVL_W+1:0] cx_e, cy_e, on_e, off_e, lvl0, lvl1, lvl2, lvl3;
  logic [3:0]        nf;

  jrdt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (x_r),
    .y_in  (y_r),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  assign cordic_start = (cmd.op == OP_SQ_X);

  always_comb begin
    abs_x = x_r[RAW_W-1] ? RAW_W'(-x_r) : RAW_W'(x_r);
    abs_y = y_r[RAW_W-1] ? RAW_W'(-y_r) : RAW_W'(y_r);
    unique case (cmd.op)
      OP_SQ_X: begin
        mul_a = abs_x;
        mul_b = abs_x;
      end
      OP_SQ_Y: begin
        mul_a = abs_y;
        mul_b = abs_y;
      end
      OP_MUL_X: begin
        mul_a = abs_x;
        mul_b = {1'b0, m_r};
      end
      OP_MUL_Y: begin
        mul_a = abs_y;
        mul_b = {1'b0, m_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod  = mul_a * mul_b;
    s_sum = s_r + prod;

    bit_v  = RAD_W'(1) << {cmd.step, 1'b0};
    sq_try = res_r + bit_v;
    trial  = NUM_W'(den_r) << cmd.step[3:0];

    // sqrt(s * 2^28) compared against the radii scaled by 2^14
    q       = res_r[Q_W-1:0];
    ib      = {1'b0, inner_dz, 14'd0};
    ob      = {1'b0, outer_dz, 14'd0};
    unit_c  = (q > ob) || ((q == ob) && (n_r != '0));
    zero_c  = (q < ib);
    remap_c = !unit_c && !zero_c && (outer_dz > inner_dz) && (s_r != '0);
    r16     = q[Q_W-1:14];
    r_cl    = (r16 < {1'b0, inner_dz}) ? {1'b0, inner_dz} : r16;
    if (r_cl > {1'b0, outer_dz}) begin
      r_cl = {1'b0, outer_dz};
    end
    qc = (quo_r > {1'b0, m_r}) ? m_r : quo_r[LVL_W-1:0];
  end

  // hysteresis on the corrected components
  always_comb begin
    cx_e  = (LVL_W+2)'(cx_r);
    cy_e  = (LVL_W+2)'(cy_r);
    on_e  = (LVL_W+2)'({1'b0, tilt_on});
    off_e = (LVL_W+2)'({1'b0, tilt_off});
    lvl0  = flags_r[0] ? off_e : on_e;
    lvl1  = flags_r[1] ? off_e : on_e;
    lvl2  = flags_r[2] ? off_e : on_e;
    lvl3  = flags_r[3] ? off_e : on_e;
    nf[0] = cx_e > lvl0;
    nf[1] = cx_e < -lvl1;
    nf[2] = cy_e < -lvl2;
    nf[3] = cy_e > lvl3;
  end

  always_comb begin
    x_nxt = x_r;  y_nxt = y_r;  s_nxt = s_r;
    n_nxt = n_r;  res_nxt = res_r;
    num_nxt = num_r;  den_nxt = den_r;  quo_nxt = quo_r;
    m_nxt = m_r;  cx_nxt = cx_r;  cy_nxt = cy_r;
    flags_nxt = flags_r;
    ox_nxt = ox_r;  oy_nxt = oy_r;  oa_nxt = oa_r;  om_nxt = om_r;
    op_nxt = op_r;  oj_nxt = oj_r;
    unique case (cmd.op)
      OP_LOAD: begin
        x_nxt  = raw_x;
        y_nxt  = raw_y;
        m_nxt  = '0;
        cx_nxt = '0;
        cy_nxt = '0;
      end
      OP_SQ_X: s_nxt = prod;
      OP_SQ_Y: begin
        s_nxt   = s_sum;
        n_nxt   = {s_sum, 28'd0};
        res_nxt = '0;
      end
      OP_SQRT: begin
        if (n_r >= sq_try) begin
          n_nxt   = n_r - sq_try;
          res_nxt = (res_r >> 1) + bit_v;
        end else begin
          res_nxt = res_r >> 1;
        end
      end
      OP_DECIDE: begin
        m_nxt   = (unit_c && (s_r != '0)) ? UNIT_M : '0;
        num_nxt = NUM_W'({LVL_W'(r_cl - {1'b0, inner_dz}), 14'd0});
        den_nxt = Q_W'(outer_dz - inner_dz);
        quo_nxt = '0;
      end
      OP_DIV: begin
        if (num_r >= trial) begin
          num_nxt = num_r - trial;
          quo_nxt = quo_r | (QUO_W'(1) << cmd.step[3:0]);
        end
      end
      OP_TAKE_M: m_nxt = (quo_r > QUO_W'(UNIT_M)) ? UNIT_M : quo_r[LVL_W-1:0];
      OP_MUL_X, OP_MUL_Y: begin
        num_nxt = NUM_W'({prod, 14'd0}) + NUM_W'(q >> 1);
        den_nxt = q;
        quo_nxt = '0;
      end
      OP_TAKE_X: cx_nxt = x_r[RAW_W-1] ? -RAW_W'(qc) : RAW_W'(qc);
      OP_TAKE_Y: cy_nxt = y_r[RAW_W-1] ? -RAW_W'(qc) : RAW_W'(qc);
      OP_OUT: begin
        ox_nxt    = cx_r;
        oy_nxt    = cy_r;
        om_nxt    = m_r;
        oa_nxt    = (m_r == '0) ? '0 : cordic_angle;
        op_nxt    = nf;
        oj_nxt    = nf & ~flags_r;
        flags_nxt = nf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
    x_r <= x_nxt;  y_r <= y_nxt;  s_r <= s_nxt;
    n_r <= n_nxt;  res_r <= res_nxt;
    num_r <= num_nxt;  den_r <= den_nxt;  quo_r <= quo_nxt;
    m_r <= m_nxt;  cx_r <= cx_nxt;  cy_r <= cy_nxt;
    ox_r <= ox_nxt;  oy_r <= oy_nxt;  oa_r <= oa_nxt;  om_r <= om_nxt;
    op_r <= op_nxt;  oj_r <= oj_nxt;
  end

  assign stat.need_mdiv   = remap_c;
  assign stat.m_zero      = (m_r == '0);
  assign stat.cordic_done = cordic_done;

  assign corrected_x       = ox_r;
  assign corrected_y       = oy_r;
  assign magnitude         = om_r;
  assign angle             = oa_r;
  assign tilt_pressed      = op_r;
  assign tilt_just_pressed = oj_r;

  a_m_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |-> m_r <= UNIT_M)
    else $error("magnitude above unit");
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT && m_r == '0) |-> (cx_r == '0 && cy_r == '0))
    else $error("nonzero vector with zero magnitude");
  a_just_sub: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_OUT |=> (oj_r & ~op_r) == 4'd0)
    else $error("just-pressed flag without pressed flag");

endmodule

// File: rtl/jrdt_ctrl.sv
// controller state machine: sequences the datapath and runs the input and result handshakes
// depends on jrdt_pkg
module jrdt_ctrl import jrdt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd.op        = OP_NONE;
    cmd.step      = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_SQ_X;
        end
      end
      ST_SQ_X: begin
        cmd.op    = OP_SQ_X;
        state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.op    = OP_SQ_Y;
        cnt_nxt   = SQRT_LAST_STEP;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.op  = OP_DECIDE;
        cnt_nxt = DIV_LAST_STEP;
        state_nxt = stat.need_mdiv ? ST_MDIV : ST_CHECK;
      end
      ST_MDIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_TAKE_M;
        end
      end
      ST_TAKE_M: begin
        cmd.op    = OP_TAKE_M;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = stat.m_zero ? ST_WAIT : ST_MUL_X;
      end
      ST_MUL_X: begin
        cmd.op    = OP_MUL_X;
        cnt_nxt   = DIV_LAST_STEP;
        state_nxt = ST_DIV_X;
      end
      ST_DIV_X: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_TAKE_X;
        end
      end
      ST_TAKE_X: begin
        cmd.op    = OP_TAKE_X;
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.op    = OP_MUL_Y;
        cnt_nxt   = DIV_LAST_STEP;
        state_nxt = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_TAKE_Y;
        end
      end
      ST_TAKE_Y: begin
        cmd.op    = OP_TAKE_Y;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.cordic_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_SQ_X)
    else $error("accepted transaction did not start");
  a_sqrt_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT && cnt_r == '0) |=> state_r == ST_DECIDE)
    else $error("square root did not finish");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_tready) |=> state_r == ST_FINISH)
    else $error("result overwrote a pending transaction");

endmodule

// File: tb/tb_joystick_radial_deadzone_tilt.sv
// regression bench for the radial dead zone / tilt flag block
// predicts every result in a behavioral model of its own; depends on rtl/jrdt_pkg.sv
`timescale 1ns / 1ps

module tb_joystick_radial_deadzone_tilt;
  import jrdt_pkg::*;

  typedef struct packed {
    logic [3:0]         just;
    logic [3:0]         pressed;
    logic signed [15:0] angle;
    logic [14:0]        mag;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
  } stick_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;

  always #5 clk = ~clk;

  joystick_radial_deadzone_tilt dut (.*);

  // predictor state
  longint inner_lvl, outer_lvl, on_lvl, off_lvl;
  logic [3:0] dir_flags;
  stick_res_t pending_res[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stall_en = 1'b1;
  int burst_mode = 0;

  localparam longint ATAN_DEG[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint stick_angle(longint x, longint y);
    longint z, t, dx, dy;
    z = 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_DEG[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_DEG[i];
      end
    end
    z = floor_shr(z + 256, 9);
    if (z > 23040) z = 23040;
    if (z < -23040) z = -23040;
    return z;
  endfunction

  function automatic longint scale_axis(longint raw, longint m, longint q);
    longint a, c;
    if (q == 0) return 0;
    a = raw < 0 ? -raw : raw;
    c = (a * m * 16384 + q / 2) / q;
    if (c > m) c = m;
    return raw < 0 ? -c : c;
  endfunction

  function automatic bit tilt_hit(bit was, longint axis, bit pos);
    longint lvl;
    lvl = was ? off_lvl : on_lvl;
    return pos ? (axis > lvl) : (axis < -lvl);
  endfunction

  function automatic stick_res_t predict_stick(logic signed [15:0] rx, logic signed [15:0] ry);
    longint x, y, s, m, r, q, cx, cy, ang;
    logic [3:0] nf;
    stick_res_t res;
    x = rx;
    y = ry;
    s = x * x + y * y;
    cx = 0; cy = 0; ang = 0; nf = '0;
    if (s > outer_lvl * outer_lvl) m = 16384;
    else if (s < inner_lvl * inner_lvl) m = 0;
    else if (outer_lvl > inner_lvl) begin
      r = int_sqrt(s);
      if (r < inner_lvl) r = inner_lvl;
      if (r > outer_lvl) r = outer_lvl;
      m = ((r - inner_lvl) << 14) / (outer_lvl - inner_lvl);
      if (m > 16384) m = 16384;
    end else m = 0;
    if (s == 0) m = 0;
    if (m != 0) begin
      q = int_sqrt(s << 28);
      cx = scale_axis(x, m, q);
      cy = scale_axis(y, m, q);
      ang = stick_angle(x, y);
    end
    nf[0] = tilt_hit(dir_flags[0], cx, 1'b1);
    nf[1] = tilt_hit(dir_flags[1], cx, 1'b0);
    nf[2] = tilt_hit(dir_flags[2], cy, 1'b0);
    nf[3] = tilt_hit(dir_flags[3], cy, 1'b1);
    res.cx = cx[15:0];
    res.cy = cy[15:0];
    res.mag = m[14:0];
    res.angle = ang[15:0];
    res.pressed = nf;
    res.just = nf & ~dir_flags;
    dir_flags = nf;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    stick_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[70:0];
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.cx !== want.cx) begin
          $display("%0t corrected_x expected %0d actual %0d", $time, want.cx, got.cx);
          errors++;
        end
        if (got.cy !== want.cy) begin
          $display("%0t corrected_y expected %0d actual %0d", $time, want.cy, got.cy);
          errors++;
        end
        if (got.mag !== want.mag) begin
          $display("%0t magnitude expected %0d actual %0d", $time, want.mag, got.mag);
          errors++;
        end
        if (got.angle !== want.angle) begin
          $display("%0t angle expected %0d actual %0d", $time, want.angle, got.angle);
          errors++;
        end
        if (got.pressed !== want.pressed) begin
          $display("%0t tilt_pressed expected %h actual %h", $time, want.pressed, got.pressed);
          errors++;
        end
        if (got.just !== want.just) begin
          $display("%0t tilt_just_pressed expected %h actual %h", $time, want.just, got.just);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (!stall_en) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [14:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INNER: inner_lvl = val;
      REG_OUTER: outer_lvl = val;
      REG_TILT_ON: on_lvl = val;
      REG_TILT_OFF: off_lvl = val;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_levels(int inr, int outr, int onl, int offl);
    drain_results();
    write_reg({6'd0, REG_INNER}, inr[14:0]);
    write_reg({6'd0, REG_OUTER}, outr[14:0]);
    write_reg({6'd0, REG_TILT_ON}, onl[14:0]);
    write_reg({6'd0, REG_TILT_OFF}, offl[14:0]);
  endtask

  // valid stays high across back-to-back items, gap only when burst ends
  task automatic send_sample(logic signed [15:0] rx, logic signed [15:0] ry);
    in_tdata <= {ry, rx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_res.push_back(predict_stick(rx, ry));
    if (burst_mode > 0) burst_mode--;
    else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_mode = $urandom_range(0, 8);
    end
  endtask

  function automatic logic signed [15:0] near_range();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 65535) - 32768;
      1: v = $urandom_range(0, 1000) - 500;
      default: v = $urandom_range(0, 32768) - 16384;
    endcase
    return v[15:0];
  endfunction

  task automatic test_directed();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd16384, 16'sd0);
    send_sample(-16'sd16384, 16'sd0);
    send_sample(16'sd0, 16'sd16384);
    send_sample(16'sd0, -16'sd16384);
    send_sample(16'sd10000, 16'sd0);
    send_sample(16'sd5000, 16'sd0);
    send_sample(16'sd4000, 16'sd4000);
    send_sample(-16'sd9000, -16'sd9000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sd4915, 16'sd0);
    send_sample(16'sd4914, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(-16'sd12000, 16'sd300);
  endtask

  task automatic test_level_corners();
    set_levels(8000, 8000, 0, 0);
    send_sample(16'sd8000, 16'sd0);
    send_sample(16'sd8001, 16'sd0);
    set_levels(12000, 6000, 16384, 16384);
    send_sample(16'sd9000, 16'sd0);
    send_sample(16'sd5000, 16'sd0);
    set_levels(0, 32767, 32767, 0);
    send_sample(16'sd100, -16'sd3);
    send_sample(16'sh8000, 16'sd0);
    set_levels(16384, 16384, 100, 32767);
    send_sample(16'sd16384, 16'sd0);
    drain_results();
    write_reg(8'd200, 15'h7fff);
    send_sample(16'sd16385, 16'sd0);
  endtask

  task automatic test_random_samples(int n, bit jitter);
    logic signed [15:0] rx, ry;
    for (int i = 0; i < n; i++) begin
      rx = near_range();
      ry = near_range();
      // sweep a pressed axis back past the off level now and then
      if (jitter && $urandom_range(0, 3) == 0) ry = -ry;
      send_sample(rx, ry);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random_samples(6, 1'b0);
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic ref_init();
    inner_lvl = INNER_RST;
    outer_lvl = OUTER_RST;
    on_lvl = TILT_ON_RST;
    off_lvl = TILT_OFF_RST;
    dir_flags = '0;
  endtask

  initial begin
    ref_init();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_level_corners();
    set_levels(4915, 14746, 8192, 4096);
    test_random_samples(200, 1'b1);
    test_backpressure();
    stall_en = 1'b0;
    set_levels($urandom_range(0, 16384), $urandom_range(0, 16384),
               $urandom_range(0, 16384), $urandom_range(0, 16384));
    test_random_samples(150, 1'b1);
    stall_en = 1'b1;
    set_levels(2000, 16000, 3000, 1000);
    test_random_samples(200, 1'b0);
    set_levels($urandom_range(0, 32767), $urandom_range(0, 32767),
               $urandom_range(0, 32767), $urandom_range(0, 32767));
    test_random_samples(130, 1'b1);
    drain_results();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
rtl/jrdt_pkg.sv
rtl/jrdt_cordic.sv
rtl/jrdt_datapath.sv
rtl/jrdt_ctrl.sv
rtl/joystick_radial_deadzone_tilt.sv
tb/tb_joystick_radial_deadzone_tilt.sv
